>>> rtl/assert_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define WGM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define WGM_NEVER(lbl, clk, rst, expr, msg) \
   `WGM_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

>>> rtl/wgm_pkg.sv
// Shared constants and types for the star-only glob matcher.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

   localparam int PATTERN_DEPTH = 32;
   localparam int IDX_W         = $clog2(PATTERN_DEPTH);
   localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
   localparam int CODE_W        = 8;

   localparam logic [CODE_W-1:0] STAR_CODE = 8'hFF;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TEXT  = 1'b1;

   // Per-beat control broadcast to every cell.
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_index;
      logic [CODE_W-1:0] wr_code;
      logic              advance;
      logic              restart;
      logic [CODE_W-1:0] text_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/wgm_cell.sv
// One pattern position: entry code, reach bit, and its links to the neighbors.
`timescale 1ns / 1ps
`default_nettype none

module wgm_cell
   import wgm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_pos,
   input  wire logic [LEN_W-1:0] len,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic             closed_in,
   output logic                  closed_out,
   input  wire logic             shift_in,
   output logic                  shift_out,
   input  wire logic             suffix_in,
   output logic                  suffix_out,
   output logic                  hit
);

   logic [CODE_W-1:0] code_ff;
   logic [CODE_W-1:0] code_in;
   logic              reach_ff;
   logic              reach_in;
   logic              in_range;
   logic              le_len;
   logic              is_star;
   logic              closed;
   logic              next_bit;
   logic              vec_bit;

   always_comb begin
      in_range   = {1'b0, cell_pos} < len;
      le_len     = {1'b0, cell_pos} <= len;
      is_star    = code_ff == STAR_CODE;
      closed     = (reach_ff & le_len) | closed_in;
      closed_out = closed & is_star & in_range;
      shift_out  = closed & in_range & !is_star & (code_ff == ctrl.text_byte);
      next_bit   = (closed & is_star & in_range) | shift_in;
      // Trailing run of stars up to the pattern end
      suffix_out = in_range ? (is_star & suffix_in) : 1'b1;
      vec_bit    = ctrl.advance ? next_bit : (reach_ff & le_len);
      hit        = vec_bit & suffix_out & le_len;
   end

   always_comb begin
      code_in  = code_ff;
      reach_in = reach_ff;
      if (ctrl.wr_en && ctrl.wr_index == cell_pos) begin
         code_in = ctrl.wr_code;
      end
      if (ctrl.restart) begin
         reach_in = cell_pos == '0;
      end else if (ctrl.advance) begin
         reach_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= cell_pos == '0;
      end else begin
         reach_ff <= reach_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wgm_rsp_buffer.sv
// Two-entry result buffer between the cell row and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module wgm_rsp_buffer
   import wgm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic push_data,
   output logic      full,
   output logic      out_valid,
   output logic      out_data,
   input  wire logic out_ready
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       slot0_ff;
   logic       slot0_in;
   logic       slot1_ff;
   logic       slot1_in;
   logic       pop;
   logic [1:0] wr_pos;

   always_comb begin
      full      = count_ff == 2'd2;
      out_valid = count_ff != 2'd0;
      out_data  = slot0_ff;
      pop       = out_valid & out_ready;
      wr_pos    = count_ff - {1'b0, pop};
      slot0_in  = slot0_ff;
      slot1_in  = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (wr_pos == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wildcard_glob_matcher_unit.sv
// Top level of the star-only glob matcher: cell row, length register, result buffer.
//
//   channel  | dir | beat carries
//   ---------+-----+--------------------------------------------------------
//   req_     | in  | pattern entry write or one text byte, tlast = end of text
//   rsp_     | out | one match flag per end of text
//   csr_     | in  | pattern length
//
// One request beat per cycle; a text beat runs the star closure through the
// cell row in the same cycle, and an end-of-text result is in the buffer on
// the next cycle. The request side stalls only while both result slots are
// full. Reset leaves the reach set at the start position and the length at 0;
// pattern entries hold nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wildcard_glob_matcher_unit
   import wgm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [4:0] entry_index, [12:5] entry_code, [20:13] text_byte, [21] has_byte
   input  wire logic [23:0]      req_tdata,
   // [0] kind
   input  wire logic             req_tuser,
   input  wire logic             req_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [0] matched
   output logic [7:0]            rsp_tdata,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [LEN_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic               reach_tail_ff;
   logic               reach_tail_in;
   logic               req_accept;
   logic               buf_full;
   logic               buf_data;
   logic               matched;
   logic               tail_hit;
   cell_ctrl_type      ctrl;
   logic [PATTERN_DEPTH:0]   closed_chain;
   logic [PATTERN_DEPTH:0]   shift_chain;
   logic [PATTERN_DEPTH:0]   suffix_chain;
   logic [PATTERN_DEPTH-1:0] hit_vec;

   assign csr_ready  = 1'b1;
   assign req_tready = !buf_full;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      ctrl.wr_en     = req_accept & (req_tuser == KIND_WRITE);
      ctrl.wr_index  = req_tdata[4:0];
      ctrl.wr_code   = req_tdata[12:5];
      ctrl.text_byte = req_tdata[20:13];
      ctrl.advance   = req_accept & (req_tuser == KIND_TEXT) & req_tdata[21];
      ctrl.restart   = req_accept & (req_tuser == KIND_TEXT) & req_tlast;
   end

   assign closed_chain[0]             = 1'b0;
   assign shift_chain[0]              = 1'b0;
   assign suffix_chain[PATTERN_DEPTH] = 1'b1;

   for (genvar p = 0; p < PATTERN_DEPTH; p++) begin : g_cell
      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_pos   (IDX_W'(p)),
         .len        (len_ff),
         .ctrl       (ctrl),
         .closed_in  (closed_chain[p]),
         .closed_out (closed_chain[p+1]),
         .shift_in   (shift_chain[p]),
         .shift_out  (shift_chain[p+1]),
         .suffix_in  (suffix_chain[p+1]),
         .suffix_out (suffix_chain[p]),
         .hit        (hit_vec[p])
      );
   end

   // Position past the last entry: reachable only by consuming entry DEPTH-1
   always_comb begin
      tail_hit = (len_ff == LEN_W'(PATTERN_DEPTH)) &
                 (ctrl.advance ? shift_chain[PATTERN_DEPTH] : reach_tail_ff);
      matched  = (|hit_vec) | tail_hit;
      reach_tail_in = reach_tail_ff;
      if (ctrl.restart) begin
         reach_tail_in = 1'b0;
      end else if (ctrl.advance) begin
         reach_tail_in = shift_chain[PATTERN_DEPTH];
      end
   end

   // Saturate the length at the store depth
   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = (csr_wdata > LEN_W'(PATTERN_DEPTH)) ? LEN_W'(PATTERN_DEPTH) : csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         reach_tail_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         reach_tail_ff <= reach_tail_in;
      end
   end

   wgm_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (ctrl.restart),
      .push_data (matched),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_data  (buf_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {7'b0, buf_data};

   `WGM_ASSERT(a_eot_gives_result, clock, reset, ctrl.restart |=> rsp_tvalid, "no result after end of text")
   `WGM_ASSERT(a_restart_clears_tail, clock, reset, ctrl.restart |=> !reach_tail_ff, "tail reach bit survived restart")
   `WGM_ASSERT(a_write_keeps_tail, clock, reset, ctrl.wr_en |=> $stable(reach_tail_ff), "pattern write moved reach set")
   `WGM_NEVER(a_stall_needs_backlog, clock, reset, !req_tready && !rsp_tvalid, "request stalled with no result pending")

endmodule

`default_nettype wire

>>> tb/glob_match_checker.sv
// Checker for the glob matcher: tracks pattern, length and reach set, compares match beats.
`timescale 1ns / 1ps

module glob_match_checker
   import wgm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [23:0]      req_tdata,
   input  wire logic             req_tuser,
   input  wire logic             req_tlast,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [7:0]       rsp_tdata,
   input  wire logic             csr_valid,
   input  wire logic             csr_ready,
   input  wire logic [LEN_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    flags_pending
);

   localparam int HAS_BIT = IDX_W + 2 * CODE_W;
   localparam logic [PATTERN_DEPTH:0] START_REACH = 1;

   logic [CODE_W-1:0]      pattern_codes [PATTERN_DEPTH];
   logic [PATTERN_DEPTH:0] reach;
   logic [LEN_W-1:0]       length_reg;
   logic                   match_due [$];

   function automatic int active_length();
      return (length_reg > PATTERN_DEPTH) ? PATTERN_DEPTH : int'(length_reg);
   endfunction

   // Extend the live positions through every star within the active length.
   function automatic logic [PATTERN_DEPTH:0] star_closure(input logic [PATTERN_DEPTH:0] live);
      logic [PATTERN_DEPTH:0] closed;
      int                     n;
      int                     p;
      n = active_length();
      closed = '0;
      for (p = 0; p <= n; p++) closed[p] = live[p];
      for (p = 0; p < n; p++)
         if (closed[p] && pattern_codes[p] == STAR_CODE) closed[p + 1] = 1'b1;
      return closed;
   endfunction

   function automatic logic [PATTERN_DEPTH:0] reach_after(input logic [CODE_W-1:0] text_byte);
      logic [PATTERN_DEPTH:0] closed;
      logic [PATTERN_DEPTH:0] next_reach;
      int                     n;
      int                     p;
      n = active_length();
      closed = star_closure(reach);
      next_reach = '0;
      for (p = 0; p < n; p++) begin
         if (closed[p]) begin
            if (pattern_codes[p] == STAR_CODE) next_reach[p] = 1'b1;
            else if (pattern_codes[p] == text_byte) next_reach[p + 1] = 1'b1;
         end
      end
      return next_reach;
   endfunction

   always @(posedge clock) begin : monitor
      logic                   want;
      logic [PATTERN_DEPTH:0] closed;
      if (reset) begin
         reach = START_REACH;
         length_reg = '0;
         match_due.delete();
         mismatches = 0;
      end else begin
         // The result is registered after acceptance, so retire first.
         if (rsp_tvalid && rsp_tready) begin
            if (match_due.size() == 0) begin
               $error("matched: expected none, actual %0d", rsp_tdata[0]);
               mismatches++;
            end else begin
               want = match_due.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $error("matched: expected %0d, actual %0d", want, rsp_tdata[0]);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) length_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_WRITE) begin
               pattern_codes[req_tdata[IDX_W-1:0]] = req_tdata[IDX_W +: CODE_W];
            end else begin
               if (req_tdata[HAS_BIT]) reach = reach_after(req_tdata[IDX_W + CODE_W +: CODE_W]);
               if (req_tlast) begin
                  closed = star_closure(reach);
                  match_due.push_back(closed[active_length()]);
                  reach = START_REACH;
               end
            end
         end
      end
      flags_pending = match_due.size();
   end

endmodule

>>> tb/tb_wildcard_glob_matcher_unit.sv
// Testbench top for the glob matcher: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_unit;
   import wgm_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [23:0]      req_tdata;
   logic             req_tuser;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [7:0]       rsp_tdata;
   logic             csr_valid;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_wdata;

   int               mismatches;
   int               flags_pending;
   int               sender_idle_pct;
   int               sink_stall_pct;
   int               counted_beats;
   bit               long_hold;
   logic [CODE_W-1:0] pattern_copy [PATTERN_DEPTH];
   logic [CODE_W-1:0] text_bytes [$];

   wildcard_glob_matcher_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   glob_match_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .flags_pending (flags_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result sink: random stalls, or one long hold-off when asked.
   initial begin : sink
      int k;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            for (k = 0; k < 300; k++) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
            long_hold = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
            @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic put_req(input logic kind, input logic [IDX_W-1:0] idx,
                          input logic [CODE_W-1:0] code, input logic [CODE_W-1:0] tbyte,
                          input logic has, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {2'b00, has, tbyte, code, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == KIND_WRITE || has || last) counted_beats++;
   endtask

   task automatic put_write(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code);
      pattern_copy[idx] = code;
      put_req(KIND_WRITE, idx, code, CODE_W'($urandom_range(255)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic put_text(input logic [CODE_W-1:0] tbyte, input logic has, input logic last);
      put_req(KIND_TEXT, IDX_W'($urandom_range(31)), CODE_W'($urandom_range(255)),
              tbyte, has, last);
   endtask

   // Drop valid, wait for every match flag, then let the pipe settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (flags_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_length(input logic [LEN_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 88) return 8'h61 + CODE_W'($urandom_range(2));
      if (r < 94) return STAR_CODE;
      return CODE_W'($urandom_range(255));
   endfunction

   task automatic load_pattern(input int n);
      int i;
      int r;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 30) put_write(IDX_W'(i), STAR_CODE);
         else if (r < 85) put_write(IDX_W'(i), 8'h61 + CODE_W'($urandom_range(2)));
         else put_write(IDX_W'(i), CODE_W'($urandom_range(255)));
      end
   endtask

   // Build a text the pattern accepts, then break it now and then.
   task automatic make_text(input int n);
      int i;
      text_bytes.delete();
      for (i = 0; i < n; i++) begin
         if (pattern_copy[i] == STAR_CODE) repeat ($urandom_range(3)) text_bytes.push_back(pick_byte());
         else text_bytes.push_back(pattern_copy[i]);
      end
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(2))
            0: if (text_bytes.size() > 0) text_bytes[$urandom_range(text_bytes.size() - 1)] = pick_byte();
            1: if (text_bytes.size() > 0) text_bytes.delete($urandom_range(text_bytes.size() - 1));
            default: text_bytes.insert($urandom_range(text_bytes.size()), pick_byte());
         endcase
      end
   endtask

   task automatic send_text(input bit close);
      int i;
      bit tail_last;
      tail_last = close && text_bytes.size() > 0 && $urandom_range(1);
      for (i = 0; i < text_bytes.size(); i++) begin
         if ($urandom_range(99) < 4) put_text(CODE_W'($urandom_range(255)), 1'b0, 1'b0);
         if ($urandom_range(99) < 3) begin
            put_write(IDX_W'($urandom_range(31)), CODE_W'($urandom_range(255)));
         end
         put_text(text_bytes[i], 1'b1, tail_last && i == text_bytes.size() - 1);
      end
      if (close && !tail_last) put_text(CODE_W'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin : stimulus
      int ph;
      int plen;
      int used;
      int target;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_TEXT;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      sender_idle_pct = 0;
      sink_stall_pct = 0;
      counted_beats = 0;
      long_hold = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Empty pattern: only the empty text matches; a bare beat does nothing.
      put_text(8'h00, 1'b0, 1'b0);
      put_text(8'h61, 1'b0, 1'b1);
      put_text(8'h61, 1'b1, 1'b1);
      set_length(6'd3);
      put_write(5'd0, 8'h61);
      put_write(5'd1, STAR_CODE);
      put_write(5'd2, 8'h62);
      put_write(5'd31, 8'h00);
      put_text(8'h61, 1'b1, 1'b0);
      put_text(8'h62, 1'b1, 1'b1);
      // Byte equal to the star code is plain text, swallowed by the star.
      put_text(8'h61, 1'b1, 1'b0);
      put_text(STAR_CODE, 1'b1, 1'b0);
      put_text(8'h63, 1'b1, 1'b0);
      put_text(8'h62, 1'b1, 1'b1);
      put_text(8'h61, 1'b1, 1'b0);
      put_text(8'h63, 1'b1, 1'b0);
      put_text(8'h00, 1'b0, 1'b1);
      put_text(8'h62, 1'b1, 1'b1);
      // Shrink the length in the middle of a text.
      put_text(8'h61, 1'b1, 1'b0);
      set_length(6'd1);
      put_text(8'h00, 1'b0, 1'b1);
      set_length(6'd3);
      put_write(5'd2, 8'h00);
      put_write(5'd0, 8'hFE);
      put_text(8'hFE, 1'b1, 1'b0);
      put_text(8'h00, 1'b1, 1'b1);

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 83; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 83; end
            default: begin sender_idle_pct = 8; sink_stall_pct = 8; end
         endcase
         case (ph)
            0: plen = 32;
            1: plen = 0;
            2: plen = 1;
            3: plen = 63;
            default: plen = $urandom_range(2, 10);
         endcase
         used = (plen > PATTERN_DEPTH) ? PATTERN_DEPTH : plen;
         set_length(LEN_W'(plen));
         load_pattern(used);
         if (ph == 4) long_hold = 1'b1;
         target = counted_beats + 60;
         while (counted_beats < target) begin
            make_text(used);
            send_text(1'b1);
         end
         // Leave a text open across the next length change now and then.
         if ($urandom_range(1)) begin
            text_bytes.delete();
            text_bytes.push_back(pick_byte());
            text_bytes.push_back(pick_byte());
            send_text(1'b0);
         end
      end

      settle();
      repeat (16) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
